[hw/rtl/tbp_pkg.sv]
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types and constants for the two-axis balance PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int INTEGRAL_WIDTH_DEF = 32;

  localparam int TIME_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int ILIM_W     = 31;
  localparam int OLIM_W     = 15;
  localparam int DRIVE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int MUL_LEN_W  = 6;

  // dt in Q16 seconds = (delta_us * 4295) >> 16
  localparam int                     DT_SCALE_W = 14;
  localparam logic [DT_SCALE_W-1:0]  DT_SCALE   = 14'd4295;
  localparam int                     DT_SHIFT   = 16;
  localparam int                     DTQ_W      = 29;
  localparam int                     INTEG_SHIFT = 16;
  localparam int                     OUT_SHIFT  = 2;

  localparam logic [ILIM_W-1:0] ILIM_RESET = 31'h7FFF_FFFF;
  localparam logic [OLIM_W-1:0] OLIM_RESET = 15'd16384;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_KI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_KD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_KP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_KI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_KD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ILIM     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OLIM     = 3'd7;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic [ILIM_W-1:0] ilim;
    logic [OLIM_W-1:0] olim;
  } limits_t;

  typedef struct packed {
    logic                 start;
    logic                 clear;
    logic [MUL_LEN_W-1:0] len;
  } mul_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/tbp_if.sv]
// ----------------------------------------------------------------------------
// tbp_if
// Valid/ready channels for update transactions and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbp_in_if #(
  parameter int SAMPLE_WIDTH = tbp_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic                           axis;
  logic signed [SAMPLE_WIDTH-1:0] angle;
  logic signed [SAMPLE_WIDTH-1:0] target_angle;
  logic signed [SAMPLE_WIDTH-1:0] gyro_rate;
  logic [tbp_pkg::TIME_W-1:0]     timestamp_us;

  modport source (
    output valid, operation, axis, angle, target_angle, gyro_rate, timestamp_us,
    input  ready
  );
  modport sink (
    input  valid, operation, axis, angle, target_angle, gyro_rate, timestamp_us,
    output ready
  );
endinterface

interface tbp_out_if ();
  logic                               valid;
  logic                               ready;
  logic                               axis_out;
  logic signed [tbp_pkg::DRIVE_W-1:0] drive;
  logic                               computed;

  modport source (
    output valid, axis_out, drive, computed,
    input  ready
  );
  modport sink (
    input  valid, axis_out, drive, computed,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/tbp_cfg.sv]
// ----------------------------------------------------------------------------
// tbp_cfg
// Gain and limit registers; presents the gain set of the selected axis.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic [tbp_pkg::CFG_IDX_W-1:0]     index,
  input  logic [tbp_pkg::CFG_DATA_W-1:0]    data,
  input  logic                              axis,
  output tbp_pkg::gains_t                   gains,
  output tbp_pkg::limits_t                  lims
);

  tbp_pkg::gains_t  pitch;
  tbp_pkg::gains_t  roll;
  tbp_pkg::limits_t limits;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch       <= '0;
      roll        <= '0;
      limits.ilim <= tbp_pkg::ILIM_RESET;
      limits.olim <= tbp_pkg::OLIM_RESET;
    end else if (we) begin
      case (index)
        tbp_pkg::REG_PITCH_KP: pitch.kp    <= data[tbp_pkg::GAIN_W-1:0];
        tbp_pkg::REG_PITCH_KI: pitch.ki    <= data[tbp_pkg::GAIN_W-1:0];
        tbp_pkg::REG_PITCH_KD: pitch.kd    <= data[tbp_pkg::GAIN_W-1:0];
        tbp_pkg::REG_ROLL_KP:  roll.kp     <= data[tbp_pkg::GAIN_W-1:0];
        tbp_pkg::REG_ROLL_KI:  roll.ki     <= data[tbp_pkg::GAIN_W-1:0];
        tbp_pkg::REG_ROLL_KD:  roll.kd     <= data[tbp_pkg::GAIN_W-1:0];
        tbp_pkg::REG_ILIM:     limits.ilim <= data[tbp_pkg::ILIM_W-1:0];
        tbp_pkg::REG_OLIM:     limits.olim <= data[tbp_pkg::OLIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign gains = axis ? roll : pitch;
  assign lims  = limits;

endmodule

`default_nettype wire

[hw/rtl/tbp_mul.sv]
// ----------------------------------------------------------------------------
// tbp_mul
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_mul #(
  parameter int MW = 33,
  parameter int NW = 17
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tbp_pkg::mul_ctl_t        ctl,
  input  logic signed [MW-1:0]     mcand,
  input  logic signed [NW-1:0]     mplier,
  output logic                     done,
  output logic signed [MW+NW-1:0]  prod
);

  localparam int PW = MW + NW;

  logic signed [PW-1:0]              mc;
  logic signed [NW-1:0]              mp;
  logic [tbp_pkg::MUL_LEN_W-1:0]     cnt;
  logic [tbp_pkg::MUL_LEN_W-1:0]     last;
  logic                              running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
      end else if (running && cnt == last) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // The top multiplier bit carries negative weight.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mc   <= PW'(mcand);
      mp   <= mplier;
      cnt  <= '0;
      last <= ctl.len - tbp_pkg::MUL_LEN_W'(1);
      if (ctl.clear) begin
        prod <= '0;
      end
    end else if (running) begin
      if (mp[0]) begin
        prod <= (cnt == last) ? prod - mc : prod + mc;
      end
      mc  <= mc <<< 1;
      mp  <= mp >>> 1;
      cnt <= cnt + tbp_pkg::MUL_LEN_W'(1);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/two_axis_balance_pid_top.sv]
// ----------------------------------------------------------------------------
// two_axis_balance_pid_top
// Pitch and roll PID loops with a clamped integrator, sharing one datapath.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries update and clear transactions; result_ch returns one
//   result transaction per accepted item. Gains and limits are written on
//   cfg_we/cfg_index/cfg_data while the block is idle.
//   An update runs five products through one bit-serial multiplier that
//   retires one multiplier bit per cycle: delta time * 4295, error * dt,
//   then kp, ki and kd terms accumulated in place. A clear, a first sample
//   or an equal timestamp runs no products. One item is in flight at a
//   time; the next item is accepted as soon as the previous one has moved
//   into the output register. Reset (rst, synchronous) zeroes the gains,
//   sets the integrator limit to its full-scale value and the output limit
//   to 16384, and marks both axes as not started.
//   When the receiver stalls, the result holds in the output register and the
//   block may take and work one more item; that item then waits in its last
//   state until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_balance_pid_top #(
  parameter int SAMPLE_WIDTH   = tbp_pkg::SAMPLE_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = tbp_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbp_pkg::CFG_DATA_W-1:0]   cfg_data,
  tbp_in_if.sink                           sample_ch,
  tbp_out_if.source                        result_ch
);

  // Error and negated gyro need one bit more than a sample.
  localparam int ERR_W = SAMPLE_WIDTH + 1;
  // Multiplicand must hold the zero-extended time delta and the integrator.
  localparam int MW = (INTEGRAL_WIDTH > tbp_pkg::TIME_W + 1) ?
                      INTEGRAL_WIDTH : tbp_pkg::TIME_W + 1;
  localparam int NW = (ERR_W > tbp_pkg::GAIN_W) ? ERR_W : tbp_pkg::GAIN_W;
  localparam int PW = MW + NW;
  localparam logic signed [PW-1:0] IMAX =
    {{(PW - INTEGRAL_WIDTH + 1){1'b0}}, {(INTEGRAL_WIDTH - 1){1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DT,
    S_IPROD,
    S_ICL1,
    S_ICL2,
    S_KP,
    S_KI,
    S_KD,
    S_OUT,
    S_DONE
  } state_t;

  state_t state;

  // Captured transaction
  logic                                op_r;
  logic                                ax_r;
  logic signed [SAMPLE_WIDTH-1:0]      angle_r;
  logic signed [SAMPLE_WIDTH-1:0]      target_r;
  logic signed [SAMPLE_WIDTH-1:0]      gyro_r;
  logic [tbp_pkg::TIME_W-1:0]          now_r;

  // Working registers and per-axis state
  logic signed [ERR_W-1:0]             err_r;
  logic signed [PW-1:0]                isum;
  logic signed [INTEGRAL_WIDTH-1:0]    integ   [2];
  logic [tbp_pkg::TIME_W-1:0]          prev    [2];
  logic                                started [2];

  // Pending result and output register
  logic                                res_axis;
  logic signed [tbp_pkg::DRIVE_W-1:0]  res_drive;
  logic                                res_computed;
  logic                                out_valid;
  logic                                out_axis;
  logic signed [tbp_pkg::DRIVE_W-1:0]  out_drive;
  logic                                out_computed;

  // Datapath
  tbp_pkg::gains_t                     gains;
  tbp_pkg::limits_t                    lims;
  tbp_pkg::mul_ctl_t                   mctl;
  logic signed [MW-1:0]                mul_a;
  logic signed [NW-1:0]                mul_b;
  logic                                mul_done;
  logic signed [PW-1:0]                mul_prod;

  logic [tbp_pkg::TIME_W-1:0]          diff;
  logic [tbp_pkg::DTQ_W-1:0]           dtq;
  logic signed [ERR_W-1:0]             neg_gyro;
  logic signed [PW-1:0]                integ_add;
  logic signed [PW-1:0]                ilim_ext;
  logic signed [PW-1:0]                olim_ext;
  logic signed [PW-1:0]                icl1;
  logic signed [PW-1:0]                icl2;
  logic signed [PW-1:0]                drive_sat;
  logic                                is_clear;

  function automatic logic signed [PW-1:0] clamp_sym(
    input logic signed [PW-1:0] x,
    input logic signed [PW-1:0] lim
  );
    if (x > lim) begin
      return lim;
    end else if (x < -lim) begin
      return -lim;
    end
    return x;
  endfunction

  tbp_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .axis  (ax_r),
    .gains (gains),
    .lims  (lims)
  );

  tbp_mul #(
    .MW (MW),
    .NW (NW)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mctl),
    .mcand  (mul_a),
    .mplier (mul_b),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  assign is_clear  = (op_r == tbp_pkg::OP_CLEAR);
  assign diff      = now_r - prev[ax_r];
  assign dtq       = mul_prod[tbp_pkg::DT_SHIFT + tbp_pkg::DTQ_W - 1:tbp_pkg::DT_SHIFT];
  assign neg_gyro  = -(ERR_W'(gyro_r));
  // Arithmetic shifts floor toward minus infinity.
  assign integ_add = PW'(integ[ax_r]) + (mul_prod >>> tbp_pkg::INTEG_SHIFT);
  assign ilim_ext  = $signed(PW'(lims.ilim));
  assign olim_ext  = $signed(PW'(lims.olim));
  assign icl1      = clamp_sym(isum, ilim_ext);
  assign icl2      = clamp_sym(isum, IMAX);
  assign drive_sat = clamp_sym(mul_prod >>> tbp_pkg::OUT_SHIFT, olim_ext);

  // Multiplier issue: the err*dt, ki and kd products start in the cycle the previous one ends; kp starts in S_ICL2.
  always_comb begin
    mctl  = '0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CHECK: begin
        if (!is_clear && started[ax_r] && diff != '0) begin
          mctl.start = 1'b1;
          mctl.clear = 1'b1;
          mctl.len   = tbp_pkg::MUL_LEN_W'(tbp_pkg::DT_SCALE_W);
          mul_a      = MW'(diff);
          mul_b      = NW'(tbp_pkg::DT_SCALE);
        end
      end
      S_DT: begin
        if (mul_done) begin
          mctl.start = 1'b1;
          mctl.clear = 1'b1;
          mctl.len   = tbp_pkg::MUL_LEN_W'(ERR_W);
          mul_a      = MW'(dtq);
          mul_b      = NW'(err_r);
        end
      end
      S_ICL2: begin
        mctl.start = 1'b1;
        mctl.clear = 1'b1;
        mctl.len   = tbp_pkg::MUL_LEN_W'(tbp_pkg::GAIN_W);
        mul_a      = MW'(err_r);
        mul_b      = NW'(gains.kp);
      end
      S_KP: begin
        // Accumulate on top of the kp term.
        if (mul_done) begin
          mctl.start = 1'b1;
          mctl.len   = tbp_pkg::MUL_LEN_W'(tbp_pkg::GAIN_W);
          mul_a      = MW'(integ[ax_r]);
          mul_b      = NW'(gains.ki);
        end
      end
      S_KI: begin
        if (mul_done) begin
          mctl.start = 1'b1;
          mctl.len   = tbp_pkg::MUL_LEN_W'(tbp_pkg::GAIN_W);
          mul_a      = MW'(neg_gyro);
          mul_b      = NW'(gains.kd);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      started[0] <= 1'b0;
      started[1] <= 1'b0;
      integ[0]   <= '0;
      integ[1]   <= '0;
      prev[0]    <= '0;
      prev[1]    <= '0;
    end else begin
      // Drop the result once the receiver takes it.
      if (result_ch.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample_ch.valid) begin
            op_r     <= sample_ch.operation;
            ax_r     <= sample_ch.axis;
            angle_r  <= sample_ch.angle;
            target_r <= sample_ch.target_angle;
            gyro_r   <= sample_ch.gyro_rate;
            now_r    <= sample_ch.timestamp_us;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_drive    <= '0;
          res_computed <= 1'b0;
          res_axis     <= is_clear ? 1'b0 : ax_r;
          err_r        <= ERR_W'(target_r) - ERR_W'(angle_r);
          if (is_clear) begin
            started[0] <= 1'b0;
            started[1] <= 1'b0;
            integ[0]   <= '0;
            integ[1]   <= '0;
            prev[0]    <= '0;
            prev[1]    <= '0;
            state      <= S_DONE;
          end else if (!started[ax_r]) begin
            // First sample only records the time.
            started[ax_r] <= 1'b1;
            prev[ax_r]    <= now_r;
            state         <= S_DONE;
          end else if (diff == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_DT;
          end
        end
        S_DT: begin
          if (mul_done) begin
            state <= S_IPROD;
          end
        end
        S_IPROD: begin
          if (mul_done) begin
            isum  <= integ_add;
            state <= S_ICL1;
          end
        end
        S_ICL1: begin
          isum  <= icl1;
          state <= S_ICL2;
        end
        S_ICL2: begin
          integ[ax_r] <= icl2[INTEGRAL_WIDTH-1:0];
          prev[ax_r]  <= now_r;
          state       <= S_KP;
        end
        S_KP: begin
          if (mul_done) begin
            state <= S_KI;
          end
        end
        S_KI: begin
          if (mul_done) begin
            state <= S_KD;
          end
        end
        S_KD: begin
          if (mul_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          res_axis     <= ax_r;
          res_drive    <= drive_sat[tbp_pkg::DRIVE_W-1:0];
          res_computed <= 1'b1;
          state        <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid || result_ch.ready) begin
            out_valid    <= 1'b1;
            out_axis     <= res_axis;
            out_drive    <= res_drive;
            out_computed <= res_computed;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign sample_ch.ready    = (state == S_IDLE);
  assign result_ch.valid    = out_valid;
  assign result_ch.axis_out = out_axis;
  assign result_ch.drive    = out_drive;
  assign result_ch.computed = out_computed;

`ifndef SYNTH
  // A product may only finish while the sequencer waits on it.
  assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_DT || state == S_IPROD || state == S_KP ||
                  state == S_KI || state == S_KD))
    else $error("multiplier finished outside a wait state");

  // A result that was not evaluated carries zero drive.
  assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && !result_ch.computed |-> result_ch.drive == '0)
    else $error("non-computed result with nonzero drive");

  // An evaluated drive stays inside the output limit.
  assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.computed |->
      (result_ch.drive <= $signed({1'b0, lims.olim})) &&
      (result_ch.drive >= -$signed({1'b0, lims.olim})))
    else $error("drive outside output limit");
`endif

endmodule

`default_nettype wire
